// ===== rtl/core/fltpe_pkg.sv =====
package fltpe_pkg;

  localparam int unsigned PoolPagesDef = 64;
  localparam int unsigned IndexBitsDef = 9;
  localparam int unsigned FrameBitsDef = 40;

  localparam int unsigned GfnW = 36;
  localparam int unsigned EntryW = 46;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PermW = 3;
  localparam int unsigned MtW = 3;
  localparam int unsigned FrameW = 40;

  localparam logic [PermW-1:0] PermRwx = 3'd7;

  typedef enum logic [1:0] {
    FuncCreate = 2'd0,
    FuncLookup = 2'd1,
    FuncInval  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    StDone    = 3'd0,
    StSame    = 3'd1,
    StDiff    = 3'd2,
    StNoPool  = 3'd3,
    StBadPerm = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_CLEAR,
    S_RESULT
  } state_e;

endpackage

// ===== rtl/core/fltpe_store.sv =====
module fltpe_store import fltpe_pkg::*; #(
  parameter int unsigned Depth = PoolPagesDef << IndexBitsDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [EntryW-1:0] wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [EntryW-1:0] rdata_o
);

  logic [EntryW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/four_level_page_table_engine.sv =====
// Each operation makes up to four dependent reads of the table memory, one per
// level, followed by the result strobe on result_valid_o.
// Throughput: one operation at a time; busy is high from acceptance through the
// result strobe. After reset the table memory is cleared one entry per cycle,
// all POOL_PAGES << INDEX_BITS entries, with busy high. The receiver cannot stall.
module four_level_page_table_engine import fltpe_pkg::*; #(
  parameter int unsigned POOL_PAGES = PoolPagesDef,
  parameter int unsigned INDEX_BITS = IndexBitsDef,
  parameter int unsigned FRAME_BITS = FrameBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func_i,
  input  logic [GfnW-1:0]   guest_frame_i,
  input  logic [PermW-1:0]  new_perm_i,
  input  logic [MtW-1:0]    new_memtype_i,
  input  logic [FRAME_BITS-1:0] new_frame_i,
  output logic              result_valid_o,
  output logic [StatusW-1:0] status_o,
  output logic [PermW-1:0]  leaf_perm_o,
  output logic [MtW-1:0]    leaf_memtype_o,
  output logic [FRAME_BITS-1:0] leaf_frame_o,
  output logic              was_present_o,
  output logic              flush_pending_o
);

  localparam int unsigned Depth = POOL_PAGES << INDEX_BITS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned PageW = $clog2(POOL_PAGES + 1);
  localparam int unsigned PidxW = $clog2(POOL_PAGES);

  state_e state_q, state_d;
  logic [AddrW:0] clr_q, clr_d;
  logic [PageW-1:0] used_q, used_d;
  logic flag_q, flag_d;
  logic [1:0] lvl_q, lvl_d;
  logic [PidxW-1:0] page_q, page_d;
  logic [1:0] func_q;
  logic [GfnW-1:0] gfn_q;
  logic [PermW-1:0] perm_q;
  logic [MtW-1:0] mt_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic [StatusW-1:0] st_q, st_d;
  logic [EntryW-1:0] leaf_q, leaf_d;
  logic pres_q, pres_d;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;
  logic [INDEX_BITS-1:0] idx;
  logic [AddrW-1:0] slot;
  logic [EntryW-1:0] want;
  logic [FrameW-1:0] nxt;
  logic accept;

  fltpe_store #(.Depth(Depth), .AddrW(AddrW)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign accept = start && !busy;
  assign idx = INDEX_BITS'(gfn_q >> (INDEX_BITS * lvl_q));
  assign slot = AddrW'({page_q, idx});
  assign raddr = slot;
  assign want = {FrameW'(frame_q), mt_q, perm_q};
  assign nxt = rdata[EntryW-1:6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      used_q <= PageW'(1);
      flag_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      used_q <= used_d;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
    page_q <= page_d;
    st_q <= st_d;
    leaf_q <= leaf_d;
    pres_q <= pres_d;
    if (accept) begin
      func_q <= func_i;
      gfn_q <= guest_frame_i;
      perm_q <= new_perm_i;
      mt_q <= new_memtype_i;
      frame_q <= new_frame_i;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    used_d = used_q;
    flag_d = flag_q;
    lvl_d = lvl_q;
    page_d = page_q;
    st_d = st_q;
    leaf_d = leaf_q;
    pres_d = pres_q;
    we = 1'b0;
    waddr = slot;
    wdata = '0;
    busy = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_q[AddrW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (AddrW+1)'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          lvl_d = 2'd3;
          page_d = '0;
          st_d = StDone;
          leaf_d = '0;
          pres_d = 1'b0;
          if (func_i == FuncCreate && new_perm_i == '0) begin
            st_d = StBadPerm;
            state_d = S_RESULT;
          end else if (func_i == FuncCreate || func_i == FuncLookup ||
                       func_i == FuncInval) begin
            state_d = S_READ;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        state_d = S_RESULT;
        if (lvl_q != 2'd0) begin
          if (rdata[2:0] == '0) begin
            if (func_q != FuncCreate) begin
              state_d = S_RESULT;
            end else if (used_q >= PageW'(POOL_PAGES)) begin
              st_d = StNoPool;
            end else begin
              we = 1'b1;
              wdata = {FrameW'(used_q), 3'd0, PermRwx};
              page_d = PidxW'(used_q);
              used_d = used_q + 1'b1;
              lvl_d = lvl_q - 2'd1;
              state_d = S_READ;
            end
          end else if (nxt < FrameW'(POOL_PAGES)) begin
            page_d = PidxW'(nxt);
            lvl_d = lvl_q - 2'd1;
            state_d = S_READ;
          end
        end else begin
          case (func_q)
            FuncCreate: begin
              if (rdata == '0) begin
                we = 1'b1;
                wdata = want;
              end else if (rdata == want) begin
                st_d = StSame;
              end else begin
                st_d = StDiff;
              end
            end
            FuncLookup: leaf_d = rdata;
            FuncInval: begin
              if (rdata[2:0] != '0) begin
                we = 1'b1;
                pres_d = 1'b1;
                flag_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_RESULT: begin
        result_valid_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign status_o = st_q;
  assign leaf_perm_o = leaf_q[2:0];
  assign leaf_memtype_o = leaf_q[5:3];
  assign leaf_frame_o = FRAME_BITS'(leaf_q[EntryW-1:6]);
  assign was_present_o = pres_q;
  assign flush_pending_o = flag_q;

endmodule

// ===== bench/fltpe_checker.sv =====
module fltpe_checker import fltpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         func_i,
  input  logic [GfnW-1:0]    guest_frame_i,
  input  logic [PermW-1:0]   new_perm_i,
  input  logic [MtW-1:0]     new_memtype_i,
  input  logic [FrameW-1:0]  new_frame_i,
  input  logic               result_valid_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [PermW-1:0]   leaf_perm_i,
  input  logic [MtW-1:0]     leaf_memtype_i,
  input  logic [FrameW-1:0]  leaf_frame_i,
  input  logic               was_present_i,
  input  logic               flush_pending_i,
  output int                 err_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Pages = PoolPagesDef;
  localparam int unsigned IdxW = IndexBitsDef;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PermW-1:0]   perm;
    logic [MtW-1:0]     memtype;
    logic [FrameW-1:0]  frame;
    logic               present;
    logic               flush;
  } leaf_result_t;

  logic [EntryW-1:0] page_mem [Pages << IdxW];
  int unsigned       pages_alloc;
  logic              flush_flag;
  leaf_result_t      expected_q[$];

  function automatic int walk_to_leaf(input logic [GfnW-1:0] gfn, input bit alloc,
                                      output int unsigned leaf_page);
    int unsigned pg;
    int unsigned slot;
    logic [EntryW-1:0] e;
    pg = 0;
    leaf_page = 0;
    for (int lv = 3; lv >= 1; lv--) begin
      slot = (pg << IdxW) | gfn[lv*IdxW +: IdxW];
      e = page_mem[slot];
      if (e[2:0] == 0) begin
        if (!alloc) return 1;
        if (pages_alloc >= Pages) return 3;
        e = {FrameW'(pages_alloc), 3'd0, PermRwx};
        page_mem[slot] = e;
        pages_alloc++;
      end
      if (e[EntryW-1:6] >= Pages) return 1;
      pg = 32'(e[EntryW-1:6]);
    end
    leaf_page = pg;
    return 0;
  endfunction

  function automatic leaf_result_t translate(input logic [1:0] fn, input logic [GfnW-1:0] gfn,
                                             input logic [PermW-1:0] perm,
                                             input logic [MtW-1:0] mt,
                                             input logic [FrameW-1:0] frm);
    leaf_result_t r;
    int unsigned pg;
    int unsigned slot;
    logic [EntryW-1:0] want;
    r = '0;
    if (fn == FuncCreate) begin
      if (perm == 0) begin
        r.status = StBadPerm;
      end else if (walk_to_leaf(gfn, 1'b1, pg) != 0) begin
        r.status = StNoPool;
      end else begin
        slot = (pg << IdxW) | gfn[IdxW-1:0];
        want = {frm, mt, perm};
        if (page_mem[slot] == 0) begin
          page_mem[slot] = want;
          r.status = StDone;
        end else if (page_mem[slot] == want) begin
          r.status = StSame;
        end else begin
          r.status = StDiff;
        end
      end
    end else if (fn == FuncLookup) begin
      if (walk_to_leaf(gfn, 1'b0, pg) == 0) begin
        slot = (pg << IdxW) | gfn[IdxW-1:0];
        {r.frame, r.memtype, r.perm} = page_mem[slot];
      end
    end else if (fn == FuncInval) begin
      if (walk_to_leaf(gfn, 1'b0, pg) == 0) begin
        slot = (pg << IdxW) | gfn[IdxW-1:0];
        if (page_mem[slot][2:0] != 0) begin
          page_mem[slot] = '0;
          r.present = 1'b1;
          flush_flag = 1'b1;
        end
      end
    end
    r.flush = flush_flag;
    return r;
  endfunction

  initial begin
    foreach (page_mem[i]) page_mem[i] = '0;
    pages_alloc = 1;
    flush_flag = 1'b0;
    err_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    leaf_result_t got;
    leaf_result_t exp_r;
    if (rst_ni) begin
      if (start_i && !busy_i)
        expected_q.push_back(translate(func_i, guest_frame_i, new_perm_i, new_memtype_i,
                                       new_frame_i));
      if (result_valid_i) begin
        got = {status_i, leaf_perm_i, leaf_memtype_i, leaf_frame_i, was_present_i,
               flush_pending_i};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, got %h", $realtime, got);
          err_count_o <= err_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got != exp_r) begin
            $display("%0t: mismatch status exp %0d got %0d, perm exp %0d got %0d",
                     $realtime, exp_r.status, got.status, exp_r.perm, got.perm);
            $display("%0t: memtype exp %0d got %0d, frame exp %h got %h", $realtime,
                     exp_r.memtype, got.memtype, exp_r.frame, got.frame);
            $display("%0t: present exp %0d got %0d, flush exp %0d got %0d", $realtime,
                     exp_r.present, got.present, exp_r.flush, got.flush);
            err_count_o <= err_count_o + 1;
          end
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
module tb import fltpe_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FuncUnused = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         func_i;
  logic [GfnW-1:0]    guest_frame_i;
  logic [PermW-1:0]   new_perm_i;
  logic [MtW-1:0]     new_memtype_i;
  logic [FrameW-1:0]  new_frame_i;
  logic               result_valid_o;
  logic [StatusW-1:0] status_o;
  logic [PermW-1:0]   leaf_perm_o;
  logic [MtW-1:0]     leaf_memtype_o;
  logic [FrameW-1:0]  leaf_frame_o;
  logic               was_present_o;
  logic               flush_pending_o;
  int                 err_count;
  int                 pending;
  bit                 idling_on;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  four_level_page_table_engine u_dut (.*);

  fltpe_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .func_i, .guest_frame_i, .new_perm_i,
    .new_memtype_i, .new_frame_i, .result_valid_i(result_valid_o), .status_i(status_o),
    .leaf_perm_i(leaf_perm_o), .leaf_memtype_i(leaf_memtype_o), .leaf_frame_i(leaf_frame_o),
    .was_present_i(was_present_o), .flush_pending_i(flush_pending_o),
    .err_count_o(err_count), .pending_o(pending)
  );

  // Called at a rising edge; returns at the edge where the transfer happens or, with idling_on set, sometimes later.
  task automatic issue(input logic [1:0] fn, input logic [GfnW-1:0] gfn,
                       input logic [PermW-1:0] perm, input logic [MtW-1:0] mt,
                       input logic [FrameW-1:0] frm);
    start <= 1'b1;
    func_i <= fn;
    guest_frame_i <= gfn;
    new_perm_i <= perm;
    new_memtype_i <= mt;
    new_frame_i <= frm;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  function automatic logic [GfnW-1:0] pick_gfn();
    logic [8:0] top_sel [4] = '{9'h000, 9'h1FF, 9'h0AA, 9'h155};
    logic [8:0] mid_sel [2] = '{9'h000, 9'h1FF};
    logic [8:0] low_sel [2] = '{9'h055, 9'h1AA};
    logic [8:0] leaf_idx;
    if ($urandom_range(0, 19) == 0) return GfnW'({$urandom, $urandom});
    leaf_idx = $urandom_range(0, 1) ? 9'($urandom_range(0, 7)) : 9'($urandom_range(504, 511));
    return {top_sel[$urandom_range(0, 3)], mid_sel[$urandom_range(0, 1)],
            low_sel[$urandom_range(0, 1)], leaf_idx};
  endfunction

  task automatic random_op();
    logic [GfnW-1:0] gfn;
    int sel;
    gfn = pick_gfn();
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      if ($urandom_range(0, 1))
        issue(FuncCreate, gfn, gfn[2:0] | 3'd1, gfn[5:3], FrameW'(gfn) ^ 40'hA5_5A00_FF00);
      else
        issue(FuncCreate, gfn, 3'($urandom_range($urandom_range(0, 9) == 0 ? 0 : 1, 7)),
              3'($urandom), FrameW'({$urandom, $urandom}));
    end else if (sel < 75) begin
      issue(FuncLookup, gfn, 3'($urandom), 3'($urandom), FrameW'({$urandom, $urandom}));
    end else if (sel < 95) begin
      issue(FuncInval, gfn, 3'($urandom), 3'($urandom), FrameW'({$urandom, $urandom}));
    end else begin
      issue(FuncUnused, gfn, 3'($urandom), 3'($urandom), FrameW'({$urandom, $urandom}));
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    func_i <= FuncLookup;
    guest_frame_i <= '0;
    new_perm_i <= '0;
    new_memtype_i <= '0;
    new_frame_i <= '0;
    idling_on = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(FuncLookup, '0, 3'd0, 3'd0, '0);
    issue(FuncInval, '1, 3'd7, 3'd7, '1);
    issue(FuncCreate, 36'h1_2345_6789, 3'd0, 3'd5, 40'h12_3456_789A);
    issue(FuncCreate, '0, 3'd7, 3'd0, '0);
    issue(FuncCreate, '0, 3'd7, 3'd0, '0);
    issue(FuncCreate, '0, 3'd1, 3'd7, '1);
    issue(FuncLookup, '0, 3'd0, 3'd0, '0);
    issue(FuncCreate, '1, 3'd5, 3'd7, '1);
    issue(FuncLookup, '1, 3'd0, 3'd0, '0);
    issue(FuncLookup, 36'hF_FFFF_FFFE, 3'd0, 3'd0, '0);
    issue(FuncUnused, '1, 3'd7, 3'd7, '1);
    issue(FuncInval, '1, 3'd0, 3'd0, '0);
    issue(FuncInval, '1, 3'd0, 3'd0, '0);
    issue(FuncLookup, '1, 3'd0, 3'd0, '0);
    issue(FuncCreate, '1, 3'd2, 3'd3, 40'h55_5555_5555);
    issue(FuncLookup, '1, 3'd0, 3'd0, '0);
    issue(FuncUnused, '0, 3'd0, 3'd0, '0);

    idling_on = 1'b1;
    for (int n = 0; n < 550; n++) begin
      if (n == 200) begin
        start <= 1'b0;
        do @(posedge clk_i); while (pending != 0 || result_valid_o || busy);
      end
      if (n == 450) idling_on = 1'b0;
      random_op();
    end
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (30) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fltpe_pkg.sv
rtl/core/fltpe_store.sv
rtl/core/four_level_page_table_engine.sv
bench/fltpe_checker.sv
bench/tb.sv
